// File: hw/rtl/stxy_pkg.sv
// Shared types, constants and bit-spreading helpers for the sky tile index block.
// Used by stxy_cfg, stxy_map and the top level; no dependencies.
`default_nettype none

package stxy_pkg;

    // Configuration defaults and register map
    localparam int unsigned MAX_TILE_ORDER_DEFAULT = 13;
    localparam logic [3:0]  TILE_ORDER_RESET       = 4'd6;

    typedef enum logic [0:0] {
        REG_TILE_ORDER = 1'b0
    } reg_index_t;

    // Masks for the shift-and-mask bit spread
    localparam logic [31:0] SPREAD_MASK_8 = 32'h00FF00FF;
    localparam logic [31:0] SPREAD_MASK_4 = 32'h0F0F0F0F;
    localparam logic [31:0] SPREAD_MASK_2 = 32'h33333333;
    localparam logic [31:0] SPREAD_MASK_1 = 32'h55555555;

    // Result of one mapping
    typedef struct packed {
        logic [29:0] tile_index;
        logic        index_valid;
    } map_result_t;

    // Spread 16 bits onto the even bit positions of a 32-bit word
    function automatic logic [31:0] spread_bits(input logic [15:0] v);
        logic [31:0] w;
        w = {16'd0, v};
        w = (w | (w << 8)) & SPREAD_MASK_8;
        w = (w | (w << 4)) & SPREAD_MASK_4;
        w = (w | (w << 2)) & SPREAD_MASK_2;
        w = (w | (w << 1)) & SPREAD_MASK_1;
        return w;
    endfunction

    // Facet number from facet grid coordinates on the diagonal band
    function automatic logic [3:0] facet_number(input logic [2:0] fx, input logic [2:0] fy);
        logic [3:0] fxy;
        logic [3:0] ring;
        logic [3:0] diag;
        fxy  = {1'b0, fx} + {1'b0, fy};
        ring = fxy[0] ? (4'd5 - (fxy >> 1)) : (4'd6 - (fxy >> 1));
        diag = {1'b0, fx} + 4'd1 - {1'b0, fy};
        return {2'b00, ring[1:0]} + {diag[1:0], 2'b00};
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/stxy_cfg.sv
// APB-style configuration register holding tile_order, with clamping to the maximum order.
// Depends on stxy_pkg.
`default_nettype none

module stxy_cfg #(
    parameter int unsigned MAX_TILE_ORDER = stxy_pkg::MAX_TILE_ORDER_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [3:0]  tile_order_eff
);

    localparam logic [3:0] MAX_ORDER = 4'(MAX_TILE_ORDER);

    logic [3:0] tile_order_reg;
    logic [3:0] tile_order_next;
    logic       wr_transfer;
    logic       sel_order;

    assign pready      = 1'b1;
    assign wr_transfer = psel & penable & pwrite;
    assign sel_order   = (paddr[2] == stxy_pkg::REG_TILE_ORDER);

    // Register write
    always_comb
    begin
        tile_order_next = tile_order_reg;
        if (wr_transfer && sel_order)
        begin
            tile_order_next = pwdata[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_order_reg <= stxy_pkg::TILE_ORDER_RESET;
        end
        else
        begin
            tile_order_reg <= tile_order_next;
        end
    end

    // Read back
    assign prdata = sel_order ? {28'd0, tile_order_reg} : 32'd0;

    // Orders above the maximum act as the maximum
    assign tile_order_eff = (tile_order_reg > MAX_ORDER) ? MAX_ORDER : tile_order_reg;

endmodule

`default_nettype wire

// File: hw/rtl/stxy_map.sv
// Combinational mapping of signed tile offsets to a nested tile index.
// Corner fold, band checks, facet number, x flip and bit interleave. Depends on stxy_pkg.
`default_nettype none

module stxy_map #(
    parameter int unsigned MAX_TILE_ORDER = stxy_pkg::MAX_TILE_ORDER_DEFAULT
) (
    input  wire logic signed [16:0]   tile_x,
    input  wire logic signed [16:0]   tile_y,
    input  wire logic                 inherited_error,
    input  wire logic        [3:0]    tile_order,
    output stxy_pkg::map_result_t     result
);

    // Wide enough for 9n plus the offset sum, with a sign bit
    localparam int CW = (((MAX_TILE_ORDER + 5) > 18) ? (MAX_TILE_ORDER + 5) : 18) + 1;

    logic signed [CW-1:0] xs, ys, n_s, nm1, n4, n9m1;
    logic signed [CW-1:0] x2, y2, fx, fy;
    logic                 low_in, high_in, low_2, high_2, in_band;
    logic                 corner, facet_ok;
    logic        [2:0]    fx_c, fy_c;
    logic        [3:0]    fi;
    logic        [15:0]   coord_mask, tx, ty;
    logic        [31:0]   in_facet;
    logic        [33:0]   base;

    always_comb
    begin
        // Tile count per edge and band limits
        xs   = CW'(tile_x);
        ys   = CW'(tile_y);
        n_s  = $signed({{(CW-1){1'b0}}, 1'b1} << tile_order);
        nm1  = n_s - 1;
        n4   = n_s <<< 2;
        n9m1 = (n_s <<< 3) + n_s - 1;

        // Fold the unused corner halves onto the used ones
        low_in  = (ys < nm1) && ((xs + ys) < nm1);
        high_in = (ys >= n9m1) || ((xs + ys) >= n9m1);
        if (low_in)
        begin
            x2 = xs + n4;
            y2 = ys + n4;
        end
        else if (high_in)
        begin
            x2 = xs - n4;
            y2 = ys - n4;
        end
        else
        begin
            x2 = xs;
            y2 = ys;
        end

        // Grid bounds after the fold
        low_2   = (y2 < nm1) && ((x2 + y2) < nm1);
        high_2  = (y2 >= n9m1) || ((x2 + y2) >= n9m1);
        in_band = !low_2 && !high_2 && !x2[CW-1] && !y2[CW-1];

        // Facet coordinates; the upper-right facet is the lower-left one
        fx     = x2 >>> tile_order;
        fy     = y2 >>> tile_order;
        corner = (fx == CW'(4)) && (fy == CW'(4));
        fx_c   = corner ? 3'd0 : fx[2:0];
        fy_c   = corner ? 3'd0 : fy[2:0];
        facet_ok = (fx < CW'(5)) && (fy < CW'(5))
                   && (({1'b0, fx_c} + 4'd1) >= {1'b0, fy_c})
                   && (({1'b0, fy_c} + 4'd1) >= {1'b0, fx_c});

        // Position within the facet, x flipped
        coord_mask = 16'((17'd1 << tile_order) - 17'd1);
        tx = ~x2[15:0] & coord_mask;
        ty = y2[15:0] & coord_mask;

        // Facet base plus interleaved position
        fi       = stxy_pkg::facet_number(fx_c, fy_c);
        base     = {30'd0, fi} << {tile_order, 1'b0};
        in_facet = stxy_pkg::spread_bits(tx) | (stxy_pkg::spread_bits(ty) << 1);

        if (!inherited_error && in_band && facet_ok)
        begin
            result.tile_index  = base[29:0] | in_facet[29:0];
            result.index_valid = 1'b1;
        end
        else
        begin
            result.tile_index  = 30'd0;
            result.index_valid = 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sky_tile_xy_to_nested_index.sv
// Sky tile offsets to nested tile index: a new command can be taken on every clock
// (busy stays low) and its result appears with a one-cycle done strobe once the start
// transfer has passed one input register and then one result register around the mapping
// logic. Results cannot be stalled, so the receiver must take every done cycle. The
// tile_order register (byte address 0) must only be written with no command in flight.
// Depends on stxy_pkg, stxy_cfg and stxy_map.
`default_nettype none

module sky_tile_xy_to_nested_index #(
    parameter int unsigned MAX_TILE_ORDER = stxy_pkg::MAX_TILE_ORDER_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [16:0] tile_x,
    input  wire logic signed [16:0] tile_y,
    input  wire logic               inherited_error,
    output logic                    done,
    output logic             [29:0] tile_index,
    output logic                    index_valid,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic        [2:0]  paddr,
    input  wire logic        [31:0] pwdata,
    output logic             [31:0] prdata,
    output logic                    pready
);

    logic [3:0]            order_eff;
    logic                  accept;
    logic                  s1_valid_reg, s1_valid_next;
    logic signed [16:0]    s1_x_reg, s1_y_reg;
    logic                  s1_err_reg;
    stxy_pkg::map_result_t map_res;
    logic                  done_reg, done_next;
    stxy_pkg::map_result_t res_reg;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Configuration register
    stxy_cfg #(
        .MAX_TILE_ORDER (MAX_TILE_ORDER)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .tile_order_eff (order_eff)
    );

    // Input register
    assign s1_valid_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg   <= tile_x;
            s1_y_reg   <= tile_y;
            s1_err_reg <= inherited_error;
        end
    end

    // Mapping logic
    stxy_map #(
        .MAX_TILE_ORDER (MAX_TILE_ORDER)
    ) u_map (
        .tile_x          (s1_x_reg),
        .tile_y          (s1_y_reg),
        .inherited_error (s1_err_reg),
        .tile_order      (order_eff),
        .result          (map_res)
    );

    // Result register
    assign done_next = s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            res_reg <= map_res;
        end
    end

    assign done        = done_reg;
    assign tile_index  = res_reg.tile_index;
    assign index_valid = res_reg.index_valid;

endmodule

`default_nettype wire

// File: hw/rtl/stxy_checker.sv
// Port-level checker for sky_tile_xy_to_nested_index, attached by bind.
// Depends only on the top-level ports.
`default_nettype none

module stxy_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        inherited_error,
    input wire logic        done,
    input wire logic [29:0] tile_index,
    input wire logic        index_valid
);

    // Every start transfer gives a done strobe
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("start transfer without done two cycles later");

    // No done strobe without a matching earlier start transfer
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("done strobe without matching start transfer");

    // A not-valid result carries index zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !index_valid) |-> (tile_index == 30'd0))
        else $error("not-valid result with nonzero index");

    // An inherited error always gives a not-valid result
    a_error_forces_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && inherited_error) |-> ##2 (done && !index_valid))
        else $error("inherited error produced a valid index");

endmodule

bind sky_tile_xy_to_nested_index stxy_checker u_stxy_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .inherited_error (inherited_error),
    .done            (done),
    .tile_index      (tile_index),
    .index_valid     (index_valid)
);

`default_nettype wire
